// ----- src/layer_z_order_table_macros.svh -----
// Assertion macros for the layer z-order table.
// Used by the top level only; relies on signals named clock and reset in scope.
`ifndef LAYER_Z_ORDER_TABLE_MACROS_SVH
`define LAYER_Z_ORDER_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LZOT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("layer_z_order_table: implication check failed");

// next-cycle implication
`define LZOT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("layer_z_order_table: next-cycle check failed");

`else

`define LZOT_ASSERT_IMP(lbl, ante, cons)
`define LZOT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/lzot_pkg.sv -----
// Shared types and constants of the layer z-order table.
// No dependencies; imported by the cell, the free-slot finder, the top level and the testbench.
package lzot_pkg;

   // fixed field widths of the request and response transactions
   localparam int LAYER_W  = 8;
   localparam int HEIGHT_W = 9;

   // free-slot search works on groups of this many layers
   localparam int GROUP_SIZE  = 32;
   localparam int GROUP_POS_W = 5;

   // request kinds
   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_FREE  = 2'd2
   } lzot_func_type;

   // response status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // shift command broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_dn;
   } lzot_shift_type;

   // per-cell select from the sequencer
   typedef struct packed {
      logic claim;   // allocate this layer
      logic drop;    // release this layer
      logic place;   // load the new height into this layer
   } lzot_sel_type;

endpackage

// ----- src/layer_z_order_table.sv -----
// Layer z-order table: accepts allocate, set-height and free requests and
// answers each with one response transaction. A request goes from acceptance
// to its response through accept, lookup of the layer's height, and apply
// to the row of layer cells; a new request is accepted while the previous
// response still waits on rsp_tready, and the apply step waits only until the
// response register is free. Every layer is a cell holding its in-use bit and
// height; a move renumbers all affected cells together in the apply step, and the
// lowest free layer for allocate comes from a two-stage registered search that
// has settled by the time the next request reaches its apply step. No clearing
// pass is needed after reset.
// Depends on lzot_pkg, lzot_cell, lzot_free_find and the assertion macro header.
`include "layer_z_order_table_macros.svh"

module layer_z_order_table
   import lzot_pkg::*;
#(
   parameter int MAX_LAYERS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = layer[7:0], height[16:8] (signed), zero fill to 24 bits
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request: tuser = func[1:0]
   input  logic [1:0]  req_tuser,
   // response: tdata = result_layer[7:0], final_height[16:8], new_top[25:17],
   //           refresh[26], zero fill to 32 bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // response: tuser = status[0]
   output logic        rsp_tuser
);

   localparam int NL = MAX_LAYERS;
   localparam int IW = $clog2(NL);
   localparam int HW = IW + 1;
   localparam int CW = ((HW > HEIGHT_W) ? HW : HEIGHT_W) + 1;
   localparam int XW = ((IW > LAYER_W) ? IW : LAYER_W) + 1;

   localparam logic signed [CW-1:0] ONE_W    = CW'(1);
   localparam logic signed [CW-1:0] MINUS1_W = '1;
   localparam logic signed [CW-1:0] ZERO_W   = '0;
   localparam logic signed [CW-1:0] MAXH_W   = CW'(NL - 1);
   localparam logic signed [HW-1:0] HIDDEN   = '1;
   localparam logic [XW-1:0]        NL_X     = XW'(NL);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_APPLY
   } state_type;

   state_type state_ff;

   // captured request
   logic [1:0]                 func_ff;
   logic [LAYER_W-1:0]         lyr_ff;
   logic signed [HEIGHT_W-1:0] hgt_ff;

   // lookup results
   logic                       alloc_ff, place_ff, drop_ff, up_ff, dn_ff, chg_ff;
   logic [IW-1:0]              idx_ff;
   logic signed [HW-1:0]       h_ff, fh_ff, top_nx_ff, top_ff;
   logic signed [CW-1:0]       lo_ff, hi_ff;

   // response register
   logic                       rsp_valid_ff;
   logic                       rsp_status_ff;
   logic [LAYER_W-1:0]         rsp_layer_ff;
   logic [HEIGHT_W-1:0]        rsp_fh_ff, rsp_top_ff;
   logic                       rsp_refresh_ff;

   // cell row
   logic [NL-1:0]              use_vec;
   logic signed [HW-1:0]       lvl_vec [NL];
   lzot_shift_type             shift;
   logic                       ff_found;
   logic [IW-1:0]              ff_idx;
   logic                       apply_go;

   // lookup logic
   logic [XW-1:0]              lyr_x, fidx_x;
   logic [IW-1:0]              idx;
   logic                       lyr_ok, used, do_move;
   logic signed [HW-1:0]       old;
   logic signed [CW-1:0]       old_w, top_w, req_w, limit_w, tgt_w, fh_w;
   logic                       place_nx, drop_nx, up_nx, dn_nx;
   logic signed [CW-1:0]       lo_nx, hi_nx, top_nx;
   logic signed [CW-1:0]       out_fh_w, out_top_w;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign apply_go   = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   // clamp the request and work out which heights shift
   always_comb begin
      lyr_x  = XW'(lyr_ff);
      idx    = lyr_x[IW-1:0];
      lyr_ok = lyr_x < NL_X;
      old    = lyr_ok ? lvl_vec[idx] : HIDDEN;
      used   = lyr_ok && use_vec[idx];
      old_w  = CW'(old);
      top_w  = CW'(top_ff);
      req_w  = CW'(hgt_ff);

      // a visible layer may go no higher than the current top
      limit_w = (old_w >= ZERO_W) ? top_w : top_w + ONE_W;
      if (limit_w > MAXH_W) begin
         limit_w = MAXH_W;
      end
      tgt_w = (req_w > limit_w) ? limit_w : req_w;
      if (tgt_w < MINUS1_W) begin
         tgt_w = MINUS1_W;
      end

      drop_nx = 1'b0;
      do_move = 1'b0;
      fh_w    = MINUS1_W;
      case (func_ff)
         FUNC_ALLOC: begin
            fh_w = MINUS1_W;
         end
         FUNC_SET: begin
            do_move = used && (tgt_w != old_w);
            fh_w    = used ? tgt_w : old_w;
         end
         FUNC_FREE: begin
            tgt_w   = MINUS1_W;
            do_move = lyr_ok && (old_w >= ZERO_W);
            drop_nx = lyr_ok;
            fh_w    = MINUS1_W;
         end
         default: begin
            fh_w = old_w;
         end
      endcase

      // four move shapes: lower, raise, hide, show
      place_nx = do_move;
      up_nx    = 1'b0;
      dn_nx    = 1'b0;
      lo_nx    = ZERO_W;
      hi_nx    = MINUS1_W;
      top_nx   = top_w;
      if (do_move) begin
         if (old_w >= ZERO_W) begin
            if (tgt_w < ZERO_W) begin
               dn_nx  = 1'b1;
               lo_nx  = old_w + ONE_W;
               hi_nx  = top_w;
               top_nx = top_w - ONE_W;
            end else if (tgt_w < old_w) begin
               up_nx = 1'b1;
               lo_nx = tgt_w;
               hi_nx = old_w - ONE_W;
            end else begin
               dn_nx = 1'b1;
               lo_nx = old_w + ONE_W;
               hi_nx = tgt_w;
            end
         end else begin
            up_nx  = 1'b1;
            lo_nx  = tgt_w;
            hi_nx  = top_w;
            top_nx = top_w + ONE_W;
         end
      end
   end

   // output widths
   always_comb begin
      fidx_x    = XW'(ff_idx);
      out_fh_w  = CW'(fh_ff);
      out_top_w = CW'(top_nx_ff);
   end

   // sequencer, lookup registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         top_ff       <= HIDDEN;
      end else begin
         if (rsp_tready && !apply_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff  <= req_tuser;
                  lyr_ff   <= req_tdata[LAYER_W-1:0];
                  hgt_ff   <= req_tdata[LAYER_W +: HEIGHT_W];
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               alloc_ff  <= (func_ff == FUNC_ALLOC);
               idx_ff    <= idx;
               place_ff  <= place_nx;
               drop_ff   <= drop_nx;
               up_ff     <= up_nx;
               dn_ff     <= dn_nx;
               chg_ff    <= place_nx;
               lo_ff     <= lo_nx;
               hi_ff     <= hi_nx;
               h_ff      <= tgt_w[HW-1:0];
               fh_ff     <= fh_w[HW-1:0];
               top_nx_ff <= top_nx[HW-1:0];
               state_ff  <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply_go) begin
                  top_ff         <= top_nx_ff;
                  rsp_valid_ff   <= 1'b1;
                  rsp_refresh_ff <= chg_ff;
                  rsp_fh_ff      <= out_fh_w[HEIGHT_W-1:0];
                  rsp_top_ff     <= out_top_w[HEIGHT_W-1:0];
                  if (alloc_ff) begin
                     rsp_status_ff <= ff_found ? STATUS_DONE : STATUS_FULL;
                     rsp_layer_ff  <= ff_found ? fidx_x[LAYER_W-1:0] : '0;
                  end else begin
                     rsp_status_ff <= STATUS_DONE;
                     rsp_layer_ff  <= lyr_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign shift.shift_up = apply_go && up_ff;
   assign shift.shift_dn = apply_go && dn_ff;

   // row of layer cells
   for (genvar i = 0; i < NL; i++) begin : g_cell
      lzot_sel_type sel;
      assign sel.claim = apply_go && alloc_ff && ff_found && (ff_idx == IW'(i));
      assign sel.drop  = apply_go && drop_ff && (idx_ff == IW'(i));
      assign sel.place = apply_go && place_ff && (idx_ff == IW'(i));

      lzot_cell #(
         .LEVEL_W (HW),
         .BOUND_W (CW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (shift),
         .sel    (sel),
         .lo     (lo_ff),
         .hi     (hi_ff),
         .h_new  (h_ff),
         .in_use (use_vec[i]),
         .level  (lvl_vec[i])
      );
   end

   // lowest free layer
   lzot_free_find #(
      .NUM   (NL),
      .IDX_W (IW)
   ) u_free_find (
      .clock    (clock),
      .reset    (reset),
      .free_vec (~use_vec),
      .found    (ff_found),
      .idx      (ff_idx)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_refresh_ff, rsp_top_ff, rsp_fh_ff, rsp_layer_ff};

   // a granted allocation leaves the layer marked in use
   `LZOT_ASSERT_NXT(a_claim_marks_use, apply_go && alloc_ff && ff_found, use_vec[$past(ff_idx)])
   // a response only appears out of the apply step
   `LZOT_ASSERT_IMP(a_rsp_from_apply, $rose(rsp_valid_ff), $past(state_ff == ST_APPLY))
   // every placement renumbers the layers in between in one direction
   `LZOT_ASSERT_IMP(a_place_shifts, apply_go && place_ff, up_ff != dn_ff)

endmodule

// ----- src/lzot_cell.sv -----
// One layer cell: holds the in-use bit and the stack height of one layer.
// Depends on lzot_pkg for the shift and select structs.
module lzot_cell
   import lzot_pkg::*;
#(
   parameter int LEVEL_W = 9,
   parameter int BOUND_W = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lzot_shift_type             ctl,
   input  lzot_sel_type               sel,
   input  logic signed [BOUND_W-1:0]  lo,
   input  logic signed [BOUND_W-1:0]  hi,
   input  logic signed [LEVEL_W-1:0]  h_new,
   output logic                       in_use,
   output logic signed [LEVEL_W-1:0]  level
);

   localparam logic signed [LEVEL_W-1:0] STEP   = LEVEL_W'(1);
   localparam logic signed [LEVEL_W-1:0] HIDDEN = '1;

   logic                      in_use_ff, in_use_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [BOUND_W-1:0] level_x;
   logic                      in_rng;

   // next state: claim, release, direct placement or a shift by one
   always_comb begin
      level_x   = BOUND_W'(level_ff);
      in_rng    = (level_x >= lo) && (level_x <= hi);
      in_use_in = in_use_ff;
      level_in  = level_ff;
      if (sel.claim) begin
         in_use_in = 1'b1;
         level_in  = HIDDEN;
      end
      if (sel.drop) begin
         in_use_in = 1'b0;
      end
      if (sel.place) begin
         level_in = h_new;
      end else if (ctl.shift_up && in_rng) begin
         level_in = level_ff + STEP;
      end else if (ctl.shift_dn && in_rng) begin
         level_in = level_ff - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= 1'b0;
         level_ff  <= HIDDEN;
      end else begin
         in_use_ff <= in_use_in;
         level_ff  <= level_in;
      end
   end

   assign in_use = in_use_ff;
   assign level  = level_ff;

endmodule

// ----- src/lzot_free_find.sv -----
// Two-stage registered search for the lowest free layer.
// Stage one encodes each group of layers, stage two picks the lowest group.
// Depends on lzot_pkg for the group size.
module lzot_free_find
   import lzot_pkg::*;
#(
   parameter int NUM   = 256,
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [NUM-1:0]   free_vec,
   output logic             found,
   output logic [IDX_W-1:0] idx
);

   localparam int NG   = (NUM + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NGW  = (NG > 1) ? $clog2(NG) : 1;
   localparam int CATW = NGW + GROUP_POS_W;

   logic [NG*GROUP_SIZE-1:0] pad;
   logic [NG-1:0]            any_in, any_ff;
   logic [GROUP_POS_W-1:0]   pos_in [NG];
   logic [GROUP_POS_W-1:0]   pos_ff [NG];
   logic [NG-1:0]            goh;
   logic [NGW-1:0]           gidx;
   logic [GROUP_POS_W-1:0]   gpos;
   logic [CATW-1:0]          cat;
   logic                     found_ff;
   logic [IDX_W-1:0]         idx_ff;

   // stage one: lowest set bit of each group, isolated by x & -x
   always_comb begin
      logic [GROUP_SIZE-1:0] grp;
      logic [GROUP_SIZE-1:0] oh;
      pad = (NG*GROUP_SIZE)'(free_vec);
      for (int g = 0; g < NG; g++) begin
         grp       = pad[g*GROUP_SIZE +: GROUP_SIZE];
         oh        = grp & (~grp + GROUP_SIZE'(1));
         any_in[g] = |grp;
         pos_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            if (oh[b]) begin
               pos_in[g] = pos_in[g] | GROUP_POS_W'(b);
            end
         end
      end
   end

   // stage two: lowest group that has a free layer
   always_comb begin
      goh  = any_ff & (~any_ff + NG'(1));
      gidx = '0;
      gpos = '0;
      for (int g = 0; g < NG; g++) begin
         if (goh[g]) begin
            gidx = gidx | NGW'(g);
            gpos = gpos | pos_ff[g];
         end
      end
      cat = {gidx, gpos};
   end

   // reset values match an all-free pool
   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff   <= '1;
         found_ff <= 1'b1;
         idx_ff   <= '0;
         for (int g = 0; g < NG; g++) begin
            pos_ff[g] <= '0;
         end
      end else begin
         any_ff   <= any_in;
         found_ff <= |any_ff;
         idx_ff   <= cat[IDX_W-1:0];
         for (int g = 0; g < NG; g++) begin
            pos_ff[g] <= pos_in[g];
         end
      end
   end

   assign found = found_ff;
   assign idx   = idx_ff;

endmodule

// ----- test/layer_z_order_table_test.sv -----
// Testbench for the layer z-order table: directed and random allocate, set-height
// and free transactions, each response checked against a behavioral stack tracker.
// Depends on lzot_pkg and the layer_z_order_table RTL.
module layer_z_order_table_test;
   import lzot_pkg::*;

   localparam int NUM_LAYERS  = 256;
   localparam int CYCLE_LIMIT = 200000;
   // request kind with no defined action; the block must ignore it
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct {
      logic                       status;
      logic [LAYER_W-1:0]         layer;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [HEIGHT_W-1:0] top;
      logic                       refresh;
   } z_result_type;

   // Tracks the layer pool and stack order, queues the response each request earns
   class z_order_tracker;
      bit           in_use[NUM_LAYERS];
      int           level[NUM_LAYERS];
      int           slot_layer[NUM_LAYERS];
      int           top;
      int           last_alloc;
      int           mismatches;
      z_result_type awaited[$];

      function new();
         foreach (level[i]) begin
            in_use[i]     = 1'b0;
            level[i]      = -1;
            slot_layer[i] = 0;
         end
         top        = -1;
         last_alloc = 0;
         mismatches = 0;
      endfunction

      function int free_count();
         int n;
         n = 0;
         foreach (in_use[i]) if (!in_use[i]) n++;
         return n;
      endfunction

      function void put(int k, int idx);
         if (k >= 0 && k < NUM_LAYERS && idx >= 0 && idx < NUM_LAYERS) begin
            slot_layer[k] = idx;
            level[idx]    = k;
         end
      endfunction

      function int layer_at(int k);
         return (k >= 0 && k < NUM_LAYERS) ? slot_layer[k] : 0;
      endfunction

      // clamp, then move the layer and shift the ones in between; 1 if anything moved
      function bit move_layer(int idx, int req);
         int old, lim, h, k;
         old = level[idx];
         lim = (old >= 0) ? top : top + 1;
         if (lim > NUM_LAYERS - 1) lim = NUM_LAYERS - 1;
         h = req;
         if (h > lim) h = lim;
         if (h < -1) h = -1;
         if (old == h) return 1'b0;
         if (old > h) begin
            if (h >= 0) begin
               for (k = old; k > h; k--) put(k, layer_at(k - 1));
               put(h, idx);
            end else begin
               // hiding: close the gap above and lower the top
               for (k = old; k < top; k++) put(k, layer_at(k + 1));
               level[idx] = -1;
               top--;
            end
         end else begin
            if (old >= 0) begin
               for (k = old; k < h; k++) put(k, layer_at(k + 1));
               put(h, idx);
            end else begin
               // showing a hidden layer: open a gap at h
               for (k = top; k >= h; k--) put(k + 1, layer_at(k));
               put(h, idx);
               top++;
            end
         end
         return 1'b1;
      endfunction

      function void note_request(logic [1:0] func, logic [LAYER_W-1:0] layer,
                                 logic signed [HEIGHT_W-1:0] height);
         z_result_type r;
         int           idx, req, i;
         bit           found;
         idx       = layer;
         req       = height;
         r.status  = STATUS_DONE;
         r.layer   = layer;
         r.height  = HEIGHT_W'(-1);
         r.refresh = 1'b0;
         if (func == FUNC_ALLOC) begin
            r.layer = '0;
            found   = 1'b0;
            for (i = 0; i < NUM_LAYERS && !found; i++) begin
               if (!in_use[i]) begin
                  in_use[i]  = 1'b1;
                  level[i]   = -1;
                  r.layer    = LAYER_W'(i);
                  last_alloc = i;
                  found      = 1'b1;
               end
            end
            if (!found) r.status = STATUS_FULL;
         end else if (func == FUNC_SET) begin
            if (in_use[idx]) r.refresh = move_layer(idx, req);
            r.height = HEIGHT_W'(level[idx]);
         end else if (func == FUNC_FREE) begin
            if (level[idx] >= 0) r.refresh = move_layer(idx, -1);
            in_use[idx] = 1'b0;
         end else begin
            r.height = HEIGHT_W'(level[idx]);
         end
         r.top = HEIGHT_W'(top);
         awaited.push_back(r);
      endfunction

      task report(string what, int got, int want);
         $display("%0t: response mismatch on %s: got %0d, want %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(logic status, logic [31:0] data);
         z_result_type w;
         if (awaited.size() == 0) begin
            report("unexpected transaction, layer", data[7:0], 0);
            return;
         end
         w = awaited.pop_front();
         if (status !== w.status) report("status", status, w.status);
         if (data[7:0] !== w.layer) report("result_layer", data[7:0], w.layer);
         if (data[16:8] !== w.height)
            report("final_height", $signed(data[16:8]), w.height);
         if (data[25:17] !== w.top) report("new_top", $signed(data[25:17]), w.top);
         if (data[26] !== w.refresh) report("refresh", data[26], w.refresh);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // layer[7:0], height[16:8], zero fill
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // result_layer[7:0], final_height[16:8],
                                  // new_top[25:17], refresh[26], zero fill
   logic        rsp_tuser;        // status[0]

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_off_req   = 1'b0;
   int cycle_count    = 0;

   z_order_tracker tracker = new();

   layer_z_order_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("layer_z_order_table_test: errors");
         $finish;
      end
   end

   // response side: random stall bursts, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = 80;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check each accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tuser, rsp_tdata);
   end

   // offer one request transaction and hold it until accepted
   task automatic send_request(logic [1:0] func, int layer, int height);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, 9'(height), 8'(layer)};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(func, 8'(layer), 9'(height));
   endtask

   // mostly layers in use, sometimes any index
   function automatic int pick_layer();
      int used[$];
      foreach (tracker.in_use[i]) if (tracker.in_use[i]) used.push_back(i);
      if (used.size() > 0 && $urandom_range(0, 4) != 0)
         return used[$urandom_range(0, used.size() - 1)];
      return $urandom_range(0, NUM_LAYERS - 1);
   endfunction

   // heights around the current stack, plus the far ends of the field
   function automatic int pick_height();
      int t;
      t = tracker.top;
      case ($urandom_range(0, 9))
         0: return -1;
         1: return t + 1;
         2: return t;
         3: return -int'($urandom_range(2, 256));
         4: return int'($urandom_range(0, 511)) - 256;
         5: return (t + 2 > 255) ? 255 : int'($urandom_range(t + 2, 255));
         default: return $urandom_range(0, (t + 1 > 255) ? 255 : t + 1);
      endcase
   endfunction

   task automatic send_random(int w_alloc, int w_set, int w_free);
      int pick, layer;
      pick  = $urandom_range(0, w_alloc + w_set + w_free + 3);
      layer = pick_layer();
      if (pick < w_alloc)
         send_request(FUNC_ALLOC, $urandom_range(0, 255), pick_height());
      else if (pick < w_alloc + w_set)
         send_request(FUNC_SET, layer, pick_height());
      else if (pick < w_alloc + w_set + w_free)
         send_request(FUNC_FREE, layer, pick_height());
      else
         send_request(FUNC_UNKNOWN, layer, pick_height());
   endtask

   initial begin
      int n, l;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first layers, clamping at both ends, moves, hides, ignored requests
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_SET, 0, 255);
      send_request(FUNC_ALLOC, 255, -256);
      send_request(FUNC_SET, 1, -256);
      send_request(FUNC_SET, 1, 0);
      send_request(FUNC_SET, 1, 1);
      send_request(FUNC_SET, 1, 1);
      send_request(FUNC_SET, 5, 3);
      send_request(FUNC_UNKNOWN, 0, -1);
      send_request(FUNC_UNKNOWN, 200, 170);
      send_request(FUNC_FREE, 200, 0);
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_SET, 2, 1);
      send_request(FUNC_SET, 0, -1);
      send_request(FUNC_SET, 2, -5);
      send_request(FUNC_FREE, 1, 0);
      send_request(FUNC_FREE, 0, 0);
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_SET, 255, 255);
      send_request(FUNC_UNKNOWN, 255, -256);
      send_request(FUNC_SET, 0, -256);
      send_request(FUNC_FREE, 0, 255);

      // mixed traffic, idling switched per stretch
      for (n = 0; n < 250; n++) begin
         if (n % 40 == 0) begin
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
         end
         send_random(30, 45, 21);
      end

      // long hold-off on the response side while requests keep coming
      sender_idles = 1'b0;
      hold_off_req = 1'b1;
      repeat (24) send_random(30, 50, 16);
      req_tvalid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;

      // fill the pool, each new layer placed into the stack
      while (tracker.free_count() > 0) begin
         send_request(FUNC_ALLOC, $urandom_range(0, 255), $urandom_range(0, 511));
         send_request(FUNC_SET, tracker.last_alloc,
                      ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, tracker.top + 1));
      end
      repeat (4) send_request(FUNC_ALLOC, $urandom_range(0, 255), pick_height());
      // show every hidden layer so the stack reaches its full height
      for (l = 0; l < NUM_LAYERS; l++)
         if (tracker.level[l] < 0) send_request(FUNC_SET, l, 255);
      l = $urandom_range(0, NUM_LAYERS - 1);
      send_request(FUNC_SET, l, -1);
      send_request(FUNC_SET, l, 255);
      send_request(FUNC_SET, l, 0);
      send_request(FUNC_SET, l, 255);
      repeat (30) send_random(10, 80, 0);

      // drain most of the pool
      while (tracker.free_count() < 160) send_random(5, 25, 66);

      // last stretch without any idling
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (120) send_random(30, 45, 21);
      req_tvalid <= 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("layer_z_order_table_test: clean");
      end else begin
         $display("layer_z_order_table_test: errors");
      end
      $finish;
   end

endmodule
